FILE: hw/rtl/bpa_pkg.sv
// bpa_pkg: shared types, codes and defaults for the buddy page allocator
package bpa_pkg;

  localparam int TOP_ORDER_DEF  = 10;
  localparam int PAGE_COUNT_DEF = 4096;
  // width for wide compares of page sums and block sizes
  localparam int BPA_XW         = 18;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_BAD_BLOCK = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  block_order;
    logic [11:0] page_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_page;
    logic [12:0] pages_free;
  } out_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_ASRCH, S_POPRD, S_POPWR, S_PUSH2, S_SWEEP,
    S_FCHK, S_FCHKE, S_MBUD, S_MBIT, S_MWALK, S_MWNXT, S_PUSH, S_IORD
  } state_t;

endpackage

FILE: hw/rtl/buddy_page_allocator.sv
// buddy_page_allocator: buddy allocator with per-order free lists over page indices
//
//   channel   ports                              direction
//   request   start, busy, in_item               in, start while busy low
//   result    out_valid, out_item                out, one-cycle strobe
//   config    psel penable pwrite paddr pwdata   apb, prdata/pready back
//
// one item at a time; busy stays high from accept to result.
// alloc: scans orders upward from the request, splits larger blocks, then marks each page of the grant.
// free: checks then clears each page of the block, then walks the order's list for each buddy merge.
// init: carves the arena into aligned blocks and clears the bitmap bit of each page.
// after reset a clearing pass sets every bit of the page bitmap.
// results cannot be stalled: each stays on out_item for its strobe cycle.
module buddy_page_allocator #(
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bpa_pkg::in_t  in_item,
  output logic          out_valid,
  output bpa_pkg::out_t out_item,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bpa_pkg::*;

  localparam int PW  = $clog2(PAGE_COUNT);
  localparam int LW  = PW + 1;
  localparam int OW  = $clog2(TOP_ORDER + 2);
  localparam int HIW = $clog2(TOP_ORDER + 1);
  localparam int XW  = BPA_XW;
  localparam logic [LW-1:0] EMPTY = LW'(PAGE_COUNT);

  state_t          state_r, state_nxt;
  in_t             in_r, in_nxt;
  logic [OW-1:0]   ord_r, ord_nxt, req_r, req_nxt;
  logic [PW-1:0]   pg_r, pg_nxt, blk_r, blk_nxt, bud_r, bud_nxt;
  logic [LW-1:0]   idx_r, idx_nxt, cnt_r, cnt_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0]   steps_r, steps_nxt, rem_r, rem_nxt, held_r, held_nxt, fc_r, fc_nxt;
  logic [LW-1:0]   heads_r [0:TOP_ORDER];
  logic [LW-1:0]   heads_nxt [0:TOP_ORDER];
  logic [12:0]     arena_r;
  logic            out_valid_r;
  out_t            out_r;

  // memories
  logic            bm_mem [0:PAGE_COUNT-1];
  logic [LW-1:0]   ln_mem [0:PAGE_COUNT-1];
  logic            bm_we, bm_wdata, bm_rd_r;
  logic [PW-1:0]   bm_waddr, bm_raddr;
  logic            ln_we;
  logic [LW-1:0]   ln_wdata, ln_rd_r;
  logic [PW-1:0]   ln_waddr, ln_raddr;

  logic            fin;
  status_t         fin_status;
  logic [PW-1:0]   fin_granted;

  // scratch
  logic [XW-1:0]   x_cnt, x_ord2, x_held;
  logic [OW-1:0]   o1;
  logic [PW-1:0]   bud_w, sweep_addr;

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_rd_r <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ln_we) begin
      ln_mem[ln_waddr] <= ln_wdata;
    end
    ln_rd_r <= ln_mem[ln_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    in_nxt      = in_r;
    ord_nxt     = ord_r;
    req_nxt     = req_r;
    pg_nxt      = pg_r;
    blk_nxt     = blk_r;
    bud_nxt     = bud_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    steps_nxt   = steps_r;
    rem_nxt     = rem_r;
    held_nxt    = held_r;
    fc_nxt      = fc_r;
    heads_nxt   = heads_r;
    bm_we       = 1'b0;
    bm_wdata    = 1'b0;
    bm_waddr    = '0;
    bm_raddr    = '0;
    ln_we       = 1'b0;
    ln_wdata    = '0;
    ln_waddr    = '0;
    ln_raddr    = '0;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_granted = '0;
    x_cnt       = '0;
    x_ord2      = '0;
    x_held      = '0;
    o1          = '0;
    bud_w       = '0;
    sweep_addr  = PW'({1'b0, pg_r} + idx_r);

    case (state_r)
      S_CLR: begin
        bm_we    = 1'b1;
        bm_wdata = 1'b1;
        bm_waddr = idx_r[PW-1:0];
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == LW'(PAGE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          in_nxt    = in_item;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        x_cnt = XW'(1) << in_r.block_order;
        case (op_t'(in_r.op))
          OP_ALLOC: begin
            if (XW'(in_r.block_order) > XW'(TOP_ORDER)) begin
              fin = 1'b1; fin_status = ST_BAD_ORDER; state_nxt = S_IDLE;
            end else begin
              ord_nxt   = OW'(in_r.block_order);
              req_nxt   = OW'(in_r.block_order);
              state_nxt = S_ASRCH;
            end
          end
          OP_FREE: begin
            if (XW'(in_r.block_order) > XW'(TOP_ORDER)) begin
              fin = 1'b1; fin_status = ST_BAD_ORDER; state_nxt = S_IDLE;
            end else if ((XW'(in_r.page_index) + x_cnt > XW'(held_r)) ||
                         ((XW'(in_r.page_index) & (x_cnt - 1'b1)) != '0)) begin
              fin = 1'b1; fin_status = ST_BAD_BLOCK; state_nxt = S_IDLE;
            end else begin
              pg_nxt    = PW'(in_r.page_index);
              ord_nxt   = OW'(in_r.block_order);
              cnt_nxt   = LW'(x_cnt);
              idx_nxt   = '0;
              state_nxt = S_FCHK;
            end
          end
          OP_INIT: begin
            x_held   = (XW'(arena_r) > XW'(PAGE_COUNT)) ? XW'(PAGE_COUNT) : XW'(arena_r);
            held_nxt = LW'(x_held);
            rem_nxt  = LW'(x_held);
            fc_nxt   = '0;
            pg_nxt   = '0;
            ord_nxt  = '0;
            for (int i = 0; i <= TOP_ORDER; i++) heads_nxt[i] = EMPTY;
            if (x_held == '0) begin
              fin = 1'b1; state_nxt = S_IDLE;
            end else begin
              state_nxt = S_IORD;
            end
          end
          default: begin
            fin = 1'b1; state_nxt = S_IDLE;
          end
        endcase
      end

      // find smallest non-empty order at or above the request
      S_ASRCH: begin
        if (XW'(ord_r) > XW'(TOP_ORDER)) begin
          fin = 1'b1; fin_status = ST_NO_MEM; state_nxt = S_IDLE;
        end else if (heads_r[ord_r[HIW-1:0]] < EMPTY) begin
          state_nxt = S_POPRD;
        end else begin
          ord_nxt = ord_r + 1'b1;
        end
      end

      S_POPRD: begin
        blk_nxt   = heads_r[ord_r[HIW-1:0]][PW-1:0];
        ln_raddr  = heads_r[ord_r[HIW-1:0]][PW-1:0];
        state_nxt = S_POPWR;
      end

      S_POPWR: begin
        heads_nxt[ord_r[HIW-1:0]] = ln_rd_r;
        if (ord_r == req_r) begin
          pg_nxt    = blk_r;
          cnt_nxt   = LW'(XW'(1) << req_r);
          idx_nxt   = '0;
          state_nxt = S_SWEEP;
        end else begin
          // push upper half first
          o1       = ord_r - 1'b1;
          bud_w    = blk_r ^ PW'(XW'(1) << o1);
          ln_we    = 1'b1;
          ln_waddr = bud_w;
          ln_wdata = heads_r[o1[HIW-1:0]];
          heads_nxt[o1[HIW-1:0]] = {1'b0, bud_w};
          ord_nxt   = o1;
          state_nxt = S_PUSH2;
        end
      end

      S_PUSH2: begin
        ln_we    = 1'b1;
        ln_waddr = blk_r;
        ln_wdata = heads_r[ord_r[HIW-1:0]];
        heads_nxt[ord_r[HIW-1:0]] = {1'b0, blk_r};
        state_nxt = S_POPRD;
      end

      // mark or clear cnt pages from pg
      S_SWEEP: begin
        bm_we    = 1'b1;
        bm_wdata = (op_t'(in_r.op) == OP_ALLOC);
        bm_waddr = sweep_addr;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == cnt_r - 1'b1) begin
          case (op_t'(in_r.op))
            OP_ALLOC: begin
              fc_nxt      = (cnt_r > fc_r) ? '0 : fc_r - cnt_r;
              fin         = 1'b1;
              fin_granted = blk_r;
              state_nxt   = S_IDLE;
            end
            OP_FREE: begin
              fc_nxt    = fc_r + cnt_r;
              state_nxt = S_MBUD;
            end
            default: begin
              fc_nxt  = fc_r + cnt_r;
              pg_nxt  = PW'({1'b0, pg_r} + cnt_r);
              rem_nxt = rem_r - cnt_r;
              ord_nxt = '0;
              if (rem_r == cnt_r) begin
                fin = 1'b1; state_nxt = S_IDLE;
              end else begin
                state_nxt = S_IORD;
              end
            end
          endcase
        end
      end

      // grow the carved block order while it fits and stays aligned
      S_IORD: begin
        x_ord2 = XW'(2) << ord_r;
        if ((XW'(ord_r) < XW'(TOP_ORDER)) && (x_ord2 <= XW'(rem_r)) &&
            ((XW'(pg_r) & (x_ord2 - 1'b1)) == '0)) begin
          ord_nxt = ord_r + 1'b1;
        end else begin
          ln_we    = 1'b1;
          ln_waddr = pg_r;
          ln_wdata = heads_r[ord_r[HIW-1:0]];
          heads_nxt[ord_r[HIW-1:0]] = {1'b0, pg_r};
          cnt_nxt   = LW'(XW'(1) << ord_r);
          idx_nxt   = '0;
          state_nxt = S_SWEEP;
        end
      end

      S_FCHK: begin
        bm_raddr  = sweep_addr;
        state_nxt = S_FCHKE;
      end

      S_FCHKE: begin
        if (!bm_rd_r) begin
          fin = 1'b1; fin_status = ST_BAD_BLOCK; state_nxt = S_IDLE;
        end else if (idx_r == cnt_r - 1'b1) begin
          idx_nxt   = '0;
          state_nxt = S_SWEEP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FCHK;
        end
      end

      S_MBUD: begin
        bud_w = pg_r ^ PW'(XW'(1) << ord_r);
        if ((XW'(ord_r) >= XW'(TOP_ORDER)) || ({1'b0, bud_w} >= held_r)) begin
          state_nxt = S_PUSH;
        end else begin
          bm_raddr  = bud_w;
          bud_nxt   = bud_w;
          state_nxt = S_MBIT;
        end
      end

      S_MBIT: begin
        if (bm_rd_r) begin
          state_nxt = S_PUSH;
        end else begin
          cur_nxt   = heads_r[ord_r[HIW-1:0]];
          prev_nxt  = EMPTY;
          steps_nxt = '0;
          state_nxt = S_MWALK;
        end
      end

      S_MWALK: begin
        if ((cur_r >= EMPTY) || (steps_r >= EMPTY)) begin
          state_nxt = S_PUSH;
        end else begin
          ln_raddr  = cur_r[PW-1:0];
          state_nxt = S_MWNXT;
        end
      end

      S_MWNXT: begin
        if (cur_r == {1'b0, bud_r}) begin
          // unlink buddy and merge
          if (prev_r >= EMPTY) begin
            heads_nxt[ord_r[HIW-1:0]] = ln_rd_r;
          end else begin
            ln_we    = 1'b1;
            ln_waddr = prev_r[PW-1:0];
            ln_wdata = ln_rd_r;
          end
          if (bud_r < pg_r) pg_nxt = bud_r;
          ord_nxt   = ord_r + 1'b1;
          state_nxt = S_MBUD;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = ln_rd_r;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_MWALK;
        end
      end

      S_PUSH: begin
        ln_we    = 1'b1;
        ln_waddr = pg_r;
        ln_wdata = heads_r[ord_r[HIW-1:0]];
        heads_nxt[ord_r[HIW-1:0]] = {1'b0, pg_r};
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      fc_r        <= '0;
      held_r      <= '0;
      arena_r     <= 13'd4096;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) heads_r[i] <= EMPTY;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fc_r        <= fc_nxt;
      held_r      <= held_nxt;
      heads_r     <= heads_nxt;
      out_valid_r <= fin;
      if (psel && penable && pwrite) begin
        arena_r <= pwdata[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    ord_r   <= ord_nxt;
    req_r   <= req_nxt;
    pg_r    <= pg_nxt;
    blk_r   <= blk_nxt;
    bud_r   <= bud_nxt;
    cnt_r   <= cnt_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    rem_r   <= rem_nxt;
    if (fin) begin
      out_r.status       <= fin_status;
      out_r.granted_page <= 12'(fin_granted);
      out_r.pages_free   <= 13'(fc_nxt);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign prdata    = (paddr == 2'd0) ? {19'd0, arena_r} : 32'd0;
  assign pready    = 1'b1;

endmodule

FILE: hw/rtl/bpa_chk.sv
// bpa_chk: port-level checks for the buddy page allocator, bound to the top level
module bpa_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bpa_pkg::out_t out_item
);
  import bpa_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item at work");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> (out_item.granted_page == '0))
    else $error("page granted on a failed item");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.pages_free <= 13'(PAGE_COUNT_DEF)))
    else $error("free page count above arena size");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
